// ===== hw/rtl/sasd_pkg.sv =====
// Package for the sine and arcsine unit: the shared control type, fixed-point
// constants and the CORDIC arctangent table. Depends on nothing.
`default_nettype none

package sasd_pkg;

    localparam int XW = 36;
    localparam int ZW = 34;

    localparam logic [1:0] ADDR_INPUT_FORMAT = 2'd0;

    localparam logic signed [XW-1:0] INV_GAIN_Q30 = 36'sd652032874;
    localparam logic signed [XW-1:0] ONE_Q30      = 36'sd1073741824;
    localparam logic signed [31:0]   DEG90_Q16    = 32'sd5898240;

    localparam logic [30:0] RECIP45      = 31'd1527099484;
    localparam logic [23:0] TURN29_DIV45 = 24'd11930464;
    localparam logic [9:0]  MOD_BIAS     = 10'd232;
    localparam logic [9:0]  DEG360       = 10'd360;

    typedef struct packed {
        logic op;
        logic last;
        logic err;
        logic pos_one;
        logic neg_one;
    } ctl_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:  val = 32'd536870912;
            5'd1:  val = 32'd316933406;
            5'd2:  val = 32'd167458907;
            5'd3:  val = 32'd85004756;
            5'd4:  val = 32'd42667331;
            5'd5:  val = 32'd21354465;
            5'd6:  val = 32'd10679838;
            5'd7:  val = 32'd5340245;
            5'd8:  val = 32'd2670163;
            5'd9:  val = 32'd1335087;
            5'd10: val = 32'd667544;
            5'd11: val = 32'd333772;
            5'd12: val = 32'd166886;
            5'd13: val = 32'd83443;
            5'd14: val = 32'd41722;
            5'd15: val = 32'd20861;
            5'd16: val = 32'd10430;
            5'd17: val = 32'd5215;
            5'd18: val = 32'd2608;
            5'd19: val = 32'd1304;
            5'd20: val = 32'd652;
            5'd21: val = 32'd326;
            5'd22: val = 32'd163;
            5'd23: val = 32'd81;
            5'd24: val = 32'd41;
            5'd25: val = 32'd20;
            5'd26: val = 32'd10;
            5'd27: val = 32'd5;
            5'd28: val = 32'd3;
            5'd29: val = 32'd1;
            5'd30: val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sine_arcsine_degrees_unit.sv =====
// Top level of the sine and arcsine unit: angle reduction, unrolled CORDIC
// pipeline and result scaling. Depends on sasd_pkg.
//
// Usage: items enter on the input channel (in_valid, in_ready, op, sample,
// last_in) and leave on the output channel (out_valid, out_ready, result,
// domain_error, last_out), one result per item, in order. Op 0 returns the
// sine of a degree angle as Q2.30, op 1 the arcsine in degrees as Q16.16.
// The APB port holds the input_format register at byte address 0; write it
// only while the pipeline is empty.
// An item accepted on the input passes four reduction stages (two of them
// built around a reciprocal multiplier), one stage per CORDIC iteration and
// one output stage before it is offered at the output.
// Throughput is one item per cycle while the receiver takes results.
// Reset empties the pipeline and sets input_format to integer samples.
// When the receiver stalls, the item at the output holds and the stages
// behind it keep filling empty slots, so in_ready drops only once every stage
// holds an item.
`default_nettype none

module sine_arcsine_degrees_unit #(
    parameter int CORDIC_STAGES = 24,
    parameter int SAMPLE_WIDTH  = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic signed [31:0] sample,
    input  logic               last_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] result,
    output logic               domain_error,
    output logic               last_out
);

    localparam int NS = CORDIC_STAGES + 5;
    localparam int XW = sasd_pkg::XW;
    localparam int ZW = sasd_pkg::ZW;

    logic                  fmt_reg;
    logic [NS-1:0]         vld_reg;
    logic [NS-1:0]         en;
    sasd_pkg::ctl_t        ctl_reg [NS-1];
    sasd_pkg::ctl_t        ctl_next;

    logic signed [31:0]    s_x;
    logic signed [31:0]    v0;
    logic [31:0]           vb0;
    logic [59:0]           p0;
    logic                  ok0;
    logic signed [31:0]    q16;
    logic signed [31:0]    t0_next;

    logic [23:0]           q0_reg;
    logic [28:0]           w0_reg;
    logic [2:0]            low3_reg;
    logic [15:0]           lo_reg [2];
    logic signed [31:0]    t0_reg [3];

    logic [28:0]           q45;
    logic [28:0]           r29;
    logic [9:0]            msum;
    logic [8:0]            m1_next;
    logic [8:0]            m1_reg;

    logic [29:0]           rem2;
    logic [60:0]           p2;
    logic [31:0]           mh_full;
    logic [24:0]           rq_reg;
    logic [31:0]           mh_reg;

    logic [31:0]           u3;
    logic signed [ZW-1:0]  zf3;

    logic signed [XW-1:0]  x_reg [CORDIC_STAGES+1];
    logic signed [XW-1:0]  y_reg [CORDIC_STAGES+1];
    logic signed [ZW-1:0]  z_reg [CORDIC_STAGES+1];
    logic signed [XW-1:0]  t_reg [CORDIC_STAGES+1];

    logic signed [43:0]    zdeg;
    logic signed [31:0]    res_next;
    logic signed [31:0]    result_reg;
    logic                  derr_reg;
    logic                  last_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == sasd_pkg::ADDR_INPUT_FORMAT) ? {31'b0, fmt_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && (paddr == sasd_pkg::ADDR_INPUT_FORMAT))
        begin
            fmt_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 0: sample widening, domain check and the first reciprocal multiply.
    always_comb
    begin
        s_x = 32'(signed'(sample[SAMPLE_WIDTH-1:0]));
        v0 = fmt_reg ? {{16{s_x[31]}}, s_x[31:16]} : s_x;
        vb0 = {~v0[31], v0[30:0]};
        p0 = 60'(vb0[31:3]) * 60'(sasd_pkg::RECIP45);
        ok0 = fmt_reg ? (s_x >= -32'sd65536 && s_x <= 32'sd65536)
                      : (s_x >= -32'sd1 && s_x <= 32'sd1);
        q16 = fmt_reg ? s_x : (s_x <<< 16);
        t0_next = q16 <<< 14;
        ctl_next.op = op;
        ctl_next.last = last_in;
        ctl_next.err = op && !ok0;
        ctl_next.pos_one = ok0 && (q16 == 32'sd65536);
        ctl_next.neg_one = ok0 && (q16 == -32'sd65536);
    end

    // Stage 1: remainder modulo 360 of the whole-degree part.
    always_comb
    begin
        q45 = 29'(q0_reg) * 29'd45;
        r29 = w0_reg - q45;
        msum = 10'({r29[5:0], low3_reg}) + sasd_pkg::MOD_BIAS;
        m1_next = (msum >= sasd_pkg::DEG360) ? 9'(msum - sasd_pkg::DEG360) : msum[8:0];
    end

    // Stage 2: scale the reduced angle to binary-angle units.
    always_comb
    begin
        rem2 = 30'({lo_reg[1], 13'b0}) + 30'({m1_reg, 5'b0}) + 30'd22;
        p2 = 61'(rem2) * 61'(sasd_pkg::RECIP45);
        mh_full = 32'(m1_reg) * 32'(sasd_pkg::TURN29_DIV45);
    end

    // Stage 3: fold the binary angle into the right half-plane.
    always_comb
    begin
        u3 = mh_reg + 32'(rq_reg);
        case (u3[31:30])
            2'b00:   zf3 = ZW'(u3);
            2'b11:   zf3 = ZW'(signed'(u3));
            default: zf3 = (ZW'(1) <<< 31) - ZW'(u3);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ctl_reg[0] <= ctl_next;
            q0_reg <= p0[59:36];
            w0_reg <= vb0[31:3];
            low3_reg <= vb0[2:0];
            lo_reg[0] <= fmt_reg ? s_x[15:0] : 16'd0;
            t0_reg[0] <= t0_next;
        end
        if (en[1])
        begin
            m1_reg <= m1_next;
            lo_reg[1] <= lo_reg[0];
            t0_reg[1] <= t0_reg[0];
        end
        if (en[2])
        begin
            rq_reg <= p2[60:36];
            mh_reg <= mh_full;
            t0_reg[2] <= t0_reg[1];
        end
        if (en[3])
        begin
            x_reg[0] <= ctl_reg[2].op ? sasd_pkg::ONE_Q30 : sasd_pkg::INV_GAIN_Q30;
            y_reg[0] <= '0;
            z_reg[0] <= ctl_reg[2].op ? '0 : zf3;
            t_reg[0] <= XW'(t0_reg[2]);
        end
        for (int k = 1; k < NS - 1; k++)
        begin
            if (en[k])
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    for (genvar gi = 0; gi < CORDIC_STAGES; gi++)
    begin : g_cordic
        logic signed [XW-1:0] xa;
        logic signed [XW-1:0] ya;
        logic signed [XW-1:0] xb;
        logic signed [XW-1:0] yb;
        logic signed [ZW-1:0] at;
        logic signed [ZW-1:0] zn;
        logic                 up;
        logic                 dir;
        logic                 is_asin;

        always_comb
        begin
            is_asin = ctl_reg[3+gi].op;
            up = (y_reg[gi] <= t_reg[gi]);
            dir = is_asin ? (x_reg[gi][XW-1] ? !up : up) : !z_reg[gi][ZW-1];
            xa = dir ? x_reg[gi] - (y_reg[gi] >>> gi) : x_reg[gi] + (y_reg[gi] >>> gi);
            ya = dir ? y_reg[gi] + (x_reg[gi] >>> gi) : y_reg[gi] - (x_reg[gi] >>> gi);
            xb = dir ? xa - (ya >>> gi) : xa + (ya >>> gi);
            yb = dir ? ya + (xa >>> gi) : ya - (xa >>> gi);
            at = ZW'(sasd_pkg::atan_turn(5'(gi)));
            if (is_asin)
            begin
                zn = dir ? z_reg[gi] + (at <<< 1) : z_reg[gi] - (at <<< 1);
            end
            else
            begin
                zn = dir ? z_reg[gi] - at : z_reg[gi] + at;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[4+gi])
            begin
                x_reg[gi+1] <= is_asin ? xb : xa;
                y_reg[gi+1] <= is_asin ? yb : ya;
                z_reg[gi+1] <= zn;
                t_reg[gi+1] <= is_asin ? t_reg[gi] + (t_reg[gi] >>> (2 * gi)) : t_reg[gi];
            end
        end
    end

    // Output stage: angle to degrees and the special cases of arcsine.
    always_comb
    begin
        zdeg = 44'(z_reg[CORDIC_STAGES]) * 44'sd360 + 44'sd32768;
        if (!ctl_reg[NS-2].op)
        begin
            res_next = y_reg[CORDIC_STAGES][31:0];
        end
        else if (ctl_reg[NS-2].err)
        begin
            res_next = '0;
        end
        else if (ctl_reg[NS-2].pos_one)
        begin
            res_next = sasd_pkg::DEG90_Q16;
        end
        else if (ctl_reg[NS-2].neg_one)
        begin
            res_next = -sasd_pkg::DEG90_Q16;
        end
        else
        begin
            res_next = 32'(zdeg >>> 16);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            result_reg <= res_next;
            derr_reg <= ctl_reg[NS-2].err;
            last_reg <= ctl_reg[NS-2].last;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign result = result_reg;
    assign domain_error = derr_reg;
    assign last_out = last_reg;

endmodule

`default_nettype wire

// ===== bench/sine_arcsine_degrees_checker.sv =====
// Checker for the sine and arcsine unit: watches both channels, predicts each
// result from the accepted item and the current input format, and compares.
// Depends on nothing beyond the signals handed in by the testbench top.
`timescale 1ns / 1ps

module sine_arcsine_degrees_checker #(
    parameter int CORDIC_STAGES = 24,
    parameter int SAMPLE_WIDTH  = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fmt_q16,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               op,
    input  logic signed [31:0] sample,
    input  logic               last_in,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] result,
    input  logic               domain_error,
    input  logic               last_out,
    output int                 fail_count,
    output int                 pending
);

    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint TURN_Q16 = 64'sd23592960;

    typedef struct packed {
        logic [31:0] value;
        logic        err;
        logic        last;
    } trig_result_t;

    trig_result_t expected_results[$];

    function automatic longint arctan_turn(int i);
        longint tbl[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
            163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
        return tbl[i];
    endfunction

    function automatic longint sine_of_degrees(longint s, logic q16);
        longint a, t, x, y, z, nx;
        longint unsigned u;
        x = 64'sd652032874;
        y = 0;
        if (!q16) begin
            a = s % 360;
            if (a < 0) a += 360;
            a = a * 65536;
        end
        else begin
            a = s % TURN_Q16;
            if (a < 0) a += TURN_Q16;
        end
        u = ((longint'(a) * 65536) + 180) / 360;
        u &= 64'hFFFF_FFFF;
        if (u < ONE_Q30) t = u;
        else if (u < 3 * ONE_Q30) t = 2 * ONE_Q30 - longint'(u);
        else t = longint'(u) - 4 * ONE_Q30;
        z = t;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= arctan_turn(i);
            end
            else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += arctan_turn(i);
            end
            x = nx;
        end
        return y;
    endfunction

    function automatic longint arcsine_degrees(longint q16);
        longint x, y, z, t, nx;
        bit d;
        x = ONE_Q30;
        y = 0;
        z = 0;
        t = q16 * 16384;
        if (q16 == 65536) return 5898240;
        if (q16 == -65536) return -5898240;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            d = (x >= 0) ? (y <= t) : !(y <= t);
            for (int k = 0; k < 2; k++) begin
                if (d) begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                end
                else begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                end
                x = nx;
            end
            z = d ? z + 2 * arctan_turn(i) : z - 2 * arctan_turn(i);
            t += t >>> (2 * i);
        end
        return (z * 360 + 32768) >>> 16;
    endfunction

    function automatic trig_result_t predict_trig(logic o, logic [31:0] raw, logic l,
                                                  logic q16);
        trig_result_t r;
        longint s, v;
        s = longint'($signed(raw << (32 - SAMPLE_WIDTH))) >>> (32 - SAMPLE_WIDTH);
        v = 0;
        r.err = 1'b0;
        r.last = l;
        if (!o) v = sine_of_degrees(s, q16);
        else if (!q16 && s >= -1 && s <= 1) v = arcsine_degrees(s * 65536);
        else if (q16 && s >= -65536 && s <= 65536) v = arcsine_degrees(s);
        else r.err = 1'b1;
        r.value = v[31:0];
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n) begin
        trig_result_t want;
        int errs;
        errs = 0;
        if (!rst_n) begin
            fail_count <= 0;
            expected_results.delete();
        end
        else begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_trig(op, sample, last_in, fmt_q16));
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item waiting: %h", result);
                    errs = errs + 1;
                end
                else begin
                    want = expected_results.pop_front();
                    if (result !== want.value) begin
                        $error("result expected %h actual %h", want.value, result);
                        errs = errs + 1;
                    end
                    if (domain_error !== want.err) begin
                        $error("domain_error expected %b actual %b", want.err,
                               domain_error);
                        errs = errs + 1;
                    end
                    if (last_out !== want.last) begin
                        $error("last_out expected %b actual %b", want.last, last_out);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

// ===== bench/sine_arcsine_degrees_unit_tb.sv =====
// Testbench top for the sine and arcsine unit: clock, reset, APB format
// writes, item stimulus with random gaps and random output stalls. Depends on
// sasd_pkg, the unit and sine_arcsine_degrees_checker.
`timescale 1ns / 1ps

module sine_arcsine_degrees_unit_tb;

    localparam int LATENCY = 24 + 5;
    localparam int STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0, in_ready, op = 1'b0, last_in = 1'b0;
    logic signed [31:0] sample = '0;
    logic out_valid, out_ready = 1'b0, last_out, domain_error;
    logic signed [31:0] result;
    logic fmt_q16 = 1'b0;
    int fail_count, pending, idle_cycles;
    int out_gap = 0;
    bit sending = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sine_arcsine_degrees_unit dut (.*);

    sine_arcsine_degrees_checker checker_i (.*);

    function automatic int gap_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    always @(posedge clk) begin
        if (out_gap > 0) begin
            out_ready <= 1'b0;
            out_gap <= out_gap - 1;
        end
        else if (!sending || $urandom_range(0, 3) != 0) begin
            out_ready <= 1'b1;
        end
        else begin
            out_ready <= 1'b0;
            out_gap <= gap_length();
        end
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_format(logic q16);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= sasd_pkg::ADDR_INPUT_FORMAT;
        pwdata <= {$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0, q16};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        fmt_q16 <= q16;
    endtask

    task automatic send_item(logic o, logic [31:0] s, logic l);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        sample <= s;
        last_in <= l;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic random_items(int count, logic q16);
        logic [31:0] s;
        logic o;
        for (int n = 0; n < count; n++) begin
            o = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0: s = $urandom;
                1: s = q16 ? $urandom_range(0, 131072) - 65536 : $urandom_range(0, 4) - 2;
                2: s = q16 ? $urandom_range(0, 47185920) - 23592960
                           : $urandom_range(0, 1440) - 720;
                default: s = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                                  : 32'h8000_0000 + $urandom_range(0, 3);
            endcase
            send_item(o, s, $urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        logic [31:0] edge_vals[10] = '{0, 1, -1, 2, -2, 90, 360, 32'h7FFF_FFFF,
                                       32'h8000_0000, 270};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        sending = 1'b1;
        foreach (edge_vals[i]) send_item(1'(i % 2), edge_vals[i], i == 9);
        send_item(1'b0, -90, 1'b1);
        drain();
        write_format(1'b1);
        send_item(1'b1, 65536, 1'b0);
        send_item(1'b1, -65536, 1'b0);
        send_item(1'b1, 65537, 1'b0);
        send_item(1'b1, -65537, 1'b0);
        send_item(1'b1, 32768, 1'b0);
        send_item(1'b0, 23592960, 1'b0);
        send_item(1'b0, -5898240, 1'b0);
        send_item(1'b0, 32'h8000_0000, 1'b1);
        random_items(150, 1'b1);
        drain();
        write_format(1'b0);
        random_items(150, 1'b0);
        drain();
        write_format(1'b1);
        random_items(150, 1'b1);
        sending = 1'b0;
        drain();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sasd_pkg.sv
hw/rtl/sine_arcsine_degrees_unit.sv
bench/sine_arcsine_degrees_checker.sv
bench/sine_arcsine_degrees_unit_tb.sv
